[src/trb_ring_producer_defines.svh]
// Assertion macros shared by the ring producer RTL
`ifndef TRB_RING_PRODUCER_DEFINES_SVH
`define TRB_RING_PRODUCER_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define TRB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("trb_ring_producer: same-cycle check failed");

// Next-cycle implication, checked outside reset
`define TRB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("trb_ring_producer: next-cycle check failed");

`endif

[src/trb_rp_pkg.sv]
// Types and constants of the ring producer
`default_nettype none
package trb_rp_pkg;

    localparam int unsigned MAX_RING_SLOTS = 256;
    localparam int unsigned IDX_W          = 8;
    localparam int unsigned SIZE_W         = 9;
    localparam int unsigned CFG_INDEX_W    = 1;
    localparam int unsigned CFG_DATA_W     = 64;

    // size used when the slot count is below two, limited by the 8-bit index
    localparam logic [SIZE_W-1:0] SMALL_SIZE_SUBST =
        SIZE_W'(MAX_RING_SLOTS > 256 ? 256 : MAX_RING_SLOTS);
    localparam logic [SIZE_W-1:0] SIZE_LIMIT = 9'd256;
    localparam logic [SIZE_W-1:0] SIZE_MIN   = 9'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_RING_SIZE = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RING_BASE = 1'b1;

    localparam logic [31:0] LINK_TYPE_BITS   = 32'(6) << 10;
    localparam logic [31:0] TOGGLE_CYCLE_BIT = 32'h0000_0002;

    typedef enum logic [0:0] {
        OP_ENQUEUE = 1'b0,
        OP_INIT    = 1'b1
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [63:0] trb_parameter;
        logic [31:0] trb_status;
        logic [31:0] trb_control;
    } trb_item_t;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [63:0]      param_word;
        logic [31:0]      status_word;
        logic [31:0]      control_word;
        logic             is_link;
        logic             last;
    } trb_word_t;

    typedef struct packed {
        logic load;
        logic need_link;
    } trb_step_ctl_t;

endpackage
`default_nettype wire

[src/trb_rp_in_stage.sv]
// Input register of the ring producer
`default_nettype none
module trb_rp_in_stage (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    in_valid,
    input  wire trb_rp_pkg::trb_item_t in_item,
    input  wire                    accept_ok,
    output logic                   in_stall,
    output logic                   item_valid,
    output trb_rp_pkg::trb_item_t  item
);
    import trb_rp_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    trb_item_t item_reg;
    logic      take;
    logic      fire;

    assign fire       = valid_reg && accept_ok;
    assign in_stall   = valid_reg && !accept_ok;
    assign take       = in_valid && !in_stall;
    assign valid_next = take ? 1'b1 : (fire ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule
`default_nettype wire

[src/trb_rp_step.sv]
// Ring state, configuration registers and per-word computation
`default_nettype none
module trb_rp_step (
    input  wire                                    clk,
    input  wire                                    rst_n,
    input  wire                                    cfg_write_enable,
    input  wire [trb_rp_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  wire [trb_rp_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  wire                                    item_valid,
    input  wire trb_rp_pkg::trb_item_t             item,
    input  wire                                    accept_ok,
    output trb_rp_pkg::trb_step_ctl_t              ctl,
    output trb_rp_pkg::trb_word_t                  first_word,
    output trb_rp_pkg::trb_word_t                  link_word
);
    import trb_rp_pkg::*;

    logic [SIZE_W-1:0] slot_count_reg;
    logic [63:0]       ring_base_reg;
    logic [IDX_W-1:0]  index_reg;
    logic [IDX_W-1:0]  index_next;
    logic              cycle_reg;
    logic              cycle_next;

    logic [SIZE_W-1:0] eff_size;
    logic [SIZE_W-1:0] link_slot;
    logic [SIZE_W-1:0] next_idx;
    logic              wrap;
    logic              is_init;
    logic              fire;
    logic              link_cycle;
    trb_word_t         entry_word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_count_reg <= SIZE_LIMIT;
            ring_base_reg  <= 64'd0;
        end
        else if (cfg_write_enable)
        begin
            case (cfg_index)
                CFG_RING_SIZE: slot_count_reg <= cfg_data[SIZE_W-1:0];
                CFG_RING_BASE: ring_base_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (slot_count_reg < SIZE_MIN)
        begin
            eff_size = SMALL_SIZE_SUBST;
        end
        else if (slot_count_reg > SIZE_LIMIT)
        begin
            eff_size = SIZE_LIMIT;
        end
        else
        begin
            eff_size = slot_count_reg;
        end
    end

    assign link_slot = eff_size - 9'd1;
    assign next_idx  = {1'b0, index_reg} + 9'd1;
    // also catches an index left past the link slot by a smaller size
    assign wrap      = next_idx >= link_slot;
    assign is_init   = (item.op == OP_INIT);
    assign fire      = item_valid && accept_ok;
    assign link_cycle = is_init ? 1'b1 : cycle_reg;

    always_comb
    begin
        link_word.idx          = link_slot[IDX_W-1:0];
        link_word.param_word   = ring_base_reg;
        link_word.status_word  = 32'd0;
        link_word.control_word = LINK_TYPE_BITS | TOGGLE_CYCLE_BIT | {31'd0, link_cycle};
        link_word.is_link      = 1'b1;
        link_word.last         = 1'b1;

        entry_word.idx          = index_reg;
        entry_word.param_word   = item.trb_parameter;
        entry_word.status_word  = item.trb_status;
        entry_word.control_word = item.trb_control | {31'd0, cycle_reg};
        entry_word.is_link      = 1'b0;
        entry_word.last         = !wrap;

        first_word    = is_init ? link_word : entry_word;
        ctl.load      = fire;
        ctl.need_link = !is_init && wrap;

        index_next = index_reg;
        cycle_next = cycle_reg;
        if (fire)
        begin
            if (is_init)
            begin
                index_next = '0;
                cycle_next = 1'b1;
            end
            else if (wrap)
            begin
                index_next = '0;
                cycle_next = !cycle_reg;
            end
            else
            begin
                index_next = next_idx[IDX_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_reg <= '0;
            cycle_reg <= 1'b1;
        end
        else
        begin
            index_reg <= index_next;
            cycle_reg <= cycle_next;
        end
    end

endmodule
`default_nettype wire

[src/trb_rp_out_stage.sv]
// Result register with a held link word for the wrap case
`default_nettype none
module trb_rp_out_stage (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire trb_rp_pkg::trb_step_ctl_t ctl,
    input  wire trb_rp_pkg::trb_word_t     first_word,
    input  wire trb_rp_pkg::trb_word_t     link_word,
    input  wire                            out_stall,
    output logic                           accept_ok,
    output logic                           out_valid,
    output trb_rp_pkg::trb_word_t          out_word
);
    import trb_rp_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    logic      pend_reg;
    logic      pend_next;
    trb_word_t word_reg;
    trb_word_t pend_word_reg;
    logic      taken;

    assign taken     = valid_reg && !out_stall;
    // while a link word waits, the current word must drain first
    assign accept_ok = !pend_reg && (!valid_reg || !out_stall);

    always_comb
    begin
        valid_next = valid_reg;
        pend_next  = pend_reg;
        if (ctl.load)
        begin
            valid_next = 1'b1;
            pend_next  = ctl.need_link;
        end
        else if (pend_reg && taken)
        begin
            valid_next = 1'b1;
            pend_next  = 1'b0;
        end
        else if (taken)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            word_reg      <= first_word;
            pend_word_reg <= link_word;
        end
        else if (pend_reg && taken)
        begin
            word_reg <= pend_word_reg;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule
`default_nettype wire

[src/trb_ring_producer.sv]
// Top level of the transfer ring producer
// Usage:
//   Input channel (in_valid / in_stall) carries one word: operation plus the
//   parameter, status and control words of a ring entry. Output channel
//   (out_valid / out_stall) carries slot writes: index, three entry words,
//   is_link and last.
//   An enqueue gives one write, or two when the ring wraps (entry, then the
//   link entry). An init gives one link write and rewinds index and cycle.
//   A taken word passes the input register, then the output register.
//   Throughput: one word per cycle when out_stall is low; a wrapping enqueue
//   holds the output register for the link write, so the next word waits
//   until the link write is taken.
//   The user writes the config port (cfg_write_enable, cfg_index, cfg_data)
//   only while the block is idle (not enforced). Reset gives a 256-slot ring,
//   base address 0, both registers empty, index 0 and cycle bit 1.
//   When the receiver stalls, the output word holds; the input register
//   still takes one word, then in_stall rises until the output drains.
`default_nettype none
`include "trb_ring_producer_defines.svh"
module trb_ring_producer (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                cfg_write_enable,
    input  wire [trb_rp_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire [trb_rp_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire                                in_valid,
    output logic                               in_stall,
    input  wire [0:0]                          operation,
    input  wire [63:0]                         trb_parameter,
    input  wire [31:0]                         trb_status,
    input  wire [31:0]                         trb_control,
    output logic                               out_valid,
    input  wire                                out_stall,
    output logic [7:0]                         write_index,
    output logic [63:0]                        write_parameter,
    output logic [31:0]                        write_status,
    output logic [31:0]                        write_control,
    output logic                               is_link,
    output logic                               last
);
    import trb_rp_pkg::*;

    trb_item_t     in_item;
    trb_item_t     item;
    logic          item_valid;
    logic          accept_ok;
    trb_step_ctl_t ctl;
    trb_word_t     first_word;
    trb_word_t     link_word;
    trb_word_t     out_word;
    logic          out_take;
    logic          link_shape_ok;

    always_comb
    begin
        in_item.op            = op_t'(operation);
        in_item.trb_parameter = trb_parameter;
        in_item.trb_status    = trb_status;
        in_item.trb_control   = trb_control;
    end

    trb_rp_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_item    (in_item),
        .accept_ok  (accept_ok),
        .in_stall   (in_stall),
        .item_valid (item_valid),
        .item       (item)
    );

    trb_rp_step u_step (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .item_valid       (item_valid),
        .item             (item),
        .accept_ok        (accept_ok),
        .ctl              (ctl),
        .first_word       (first_word),
        .link_word        (link_word)
    );

    trb_rp_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .first_word (first_word),
        .link_word  (link_word),
        .out_stall  (out_stall),
        .accept_ok  (accept_ok),
        .out_valid  (out_valid),
        .out_word   (out_word)
    );

    assign write_index     = out_word.idx;
    assign write_parameter = out_word.param_word;
    assign write_status    = out_word.status_word;
    assign write_control   = out_word.control_word;
    assign is_link         = out_word.is_link;
    assign last            = out_word.last;

    assign out_take      = out_valid && !out_stall;
    assign link_shape_ok = last && write_status == 32'd0
                           && write_control[15:10] == 6'd6 && write_control[1];

    // an entry word with last low must be followed by its link word
    `TRB_ASSERT_NEXT(a_link_follows, clk, rst_n, out_take && !last, out_valid && is_link && last)
    // a link word always closes the item and carries the link encoding
    `TRB_ASSERT_NOW(a_link_shape, clk, rst_n, out_valid && is_link, link_shape_ok)
    // the input side only stalls while it holds a word
    `TRB_ASSERT_NOW(a_stall_holds, clk, rst_n, in_stall, item_valid && out_valid)

endmodule
`default_nettype wire

[tb/sv/tb_trb_ring_producer.sv]
// Self-checking testbench for the transfer ring producer: directed and random words
`timescale 1ns / 100ps
module tb_trb_ring_producer;
    import trb_rp_pkg::*;

    localparam int          LONG_HOLD      = 200;
    localparam logic [31:0] LINK_CTRL_BITS = 32'h0000_1802; // type 6 in 15:10, toggle-cycle

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_write_enable = 1'b0;
    logic [CFG_INDEX_W-1:0]  cfg_index = CFG_RING_SIZE;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic [0:0]              operation = OP_ENQUEUE;
    logic [63:0]             trb_parameter = '0;
    logic [31:0]             trb_status = '0;
    logic [31:0]             trb_control = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic [7:0]              write_index;
    logic [63:0]             write_parameter;
    logic [31:0]             write_status;
    logic [31:0]             write_control;
    logic                    is_link;
    logic                    last;

    // ring model state and its copy of the registers
    logic [8:0]  size_reg = 9'd256;
    logic [63:0] base_reg = '0;
    logic [7:0]  enq_slot = '0;
    logic        cycle_state = 1'b1;

    trb_word_t slot_writes_due[$];

    int mismatch_count = 0;
    int words_sent = 0;
    int writes_checked = 0;
    int link_writes = 0;
    int init_words = 0;
    int reg_writes = 0;

    bit tx_idling = 1'b1;
    bit rx_idling = 1'b1;
    int hold_req = 0;
    int hold_ack = 0;
    int hold_left = 0;
    int rx_left = 0;

    trb_ring_producer dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .operation        (operation),
        .trb_parameter    (trb_parameter),
        .trb_status       (trb_status),
        .trb_control      (trb_control),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .write_index      (write_index),
        .write_parameter  (write_parameter),
        .write_status     (write_status),
        .write_control    (write_control),
        .is_link          (is_link),
        .last             (last)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("Timeout with %0d writes still due", slot_writes_due.size());
        $display("Test completed with failures");
        $finish;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic trb_word_t link_word(logic [7:0] slot, logic cyc);
        trb_word_t w;
        w.idx          = slot;
        w.param_word   = base_reg;
        w.status_word  = '0;
        w.control_word = LINK_CTRL_BITS | {31'd0, cyc};
        w.is_link      = 1'b1;
        w.last         = 1'b1;
        return w;
    endfunction

    // works out the slot writes for one accepted word and advances the ring state
    function automatic void predict_slot_writes(op_t op, logic [63:0] p, logic [31:0] s,
                                                logic [31:0] c);
        logic [8:0] eff;
        logic [7:0] link_slot;
        logic [8:0] next;
        trb_word_t  w;
        eff = size_reg;
        if (eff < 9'd2)
            eff = 9'd256;
        if (eff > 9'd256)
            eff = 9'd256;
        link_slot = 8'(eff - 9'd1);
        if (op == OP_INIT)
        begin
            slot_writes_due.push_back(link_word(link_slot, 1'b1));
            enq_slot    = '0;
            cycle_state = 1'b1;
            init_words++;
            link_writes++;
            return;
        end
        next           = {1'b0, enq_slot} + 9'd1;
        w.idx          = enq_slot;
        w.param_word   = p;
        w.status_word  = s;
        w.control_word = c | {31'd0, cycle_state};
        w.is_link      = 1'b0;
        w.last         = (next < {1'b0, link_slot});
        slot_writes_due.push_back(w);
        if (next >= {1'b0, link_slot})
        begin
            slot_writes_due.push_back(link_word(link_slot, cycle_state));
            enq_slot    = '0;
            cycle_state = ~cycle_state;
            link_writes++;
        end
        else
            enq_slot = next[7:0];
    endfunction

    task automatic report_mismatch(string what);
        if (mismatch_count < 40)
            $display("MISMATCH at %0t: %s", $time, what);
        mismatch_count++;
    endtask

    // output side: stall bursts, plus a long hold when the test asks for one
    always @(posedge clk)
    begin
        if (hold_req != hold_ack)
        begin
            hold_ack  = hold_req;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (rx_left > 0)
        begin
            rx_left--;
            out_stall <= 1'b1;
        end
        else if (rx_idling && $urandom_range(0, 5) == 0)
        begin
            rx_left = $urandom_range(1, 19) - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        trb_word_t w;
        if (rst_n && out_valid && !out_stall)
        begin
            if (slot_writes_due.size() == 0)
                report_mismatch($sformatf("unexpected write to slot %0d", write_index));
            else
            begin
                w = slot_writes_due.pop_front();
                writes_checked++;
                if (write_index !== w.idx)
                    report_mismatch($sformatf("write_index got %0d want %0d",
                                              write_index, w.idx));
                if (write_parameter !== w.param_word)
                    report_mismatch($sformatf("write_parameter got %h want %h",
                                              write_parameter, w.param_word));
                if (write_status !== w.status_word)
                    report_mismatch($sformatf("write_status got %h want %h",
                                              write_status, w.status_word));
                if (write_control !== w.control_word)
                    report_mismatch($sformatf("write_control got %h want %h",
                                              write_control, w.control_word));
                if (is_link !== w.is_link)
                    report_mismatch($sformatf("is_link got %b want %b", is_link, w.is_link));
                if (last !== w.last)
                    report_mismatch($sformatf("last got %b want %b", last, w.last));
            end
        end
    end

    // called at a rising edge; returns at the edge where the word was taken
    task automatic send_word(op_t op, logic [63:0] p, logic [31:0] s, logic [31:0] c);
        int gap;
        if (tx_idling && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 19);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        operation     <= op;
        trb_parameter <= p;
        trb_status    <= s;
        trb_control   <= c;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_slot_writes(op, p, s, c);
        words_sent++;
    endtask

    task automatic send_random_word(int init_odds);
        op_t op;
        op = ($urandom_range(0, init_odds) == 0) ? OP_INIT : OP_ENQUEUE;
        send_word(op, rand64(), $urandom, $urandom);
    endtask

    // lets every due write drain, then waits out any word still in flight
    task automatic settle_ring();
        in_valid <= 1'b0;
        while (slot_writes_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [63:0] val);
        cfg_write_enable <= 1'b1;
        cfg_index        <= idx;
        cfg_data         <= val;
        @(posedge clk);
        cfg_write_enable <= 1'b0;
        if (idx == CFG_RING_SIZE)
            size_reg = val[8:0];
        else
            base_reg = val;
        reg_writes++;
        @(posedge clk);
    endtask

    function automatic logic [8:0] pick_slot_count();
        case ($urandom_range(0, 9))
            0:       return 9'($urandom_range(0, 1));
            1:       return 9'($urandom_range(257, 511));
            2:       return 9'd256;
            3, 4:    return 9'($urandom_range(17, 255));
            default: return 9'($urandom_range(2, 16));
        endcase
    endfunction

    task automatic test_directed();
        send_word(OP_ENQUEUE, '0, '0, '0);
        send_word(OP_ENQUEUE, '1, '1, '1);
        send_word(OP_INIT, '1, '1, '1);
        settle_ring();
        // smallest ring: every enqueue wraps
        write_reg(CFG_RING_SIZE, 64'd2);
        write_reg(CFG_RING_BASE, '1);
        repeat (3) send_word(OP_ENQUEUE, rand64(), $urandom, 32'hFFFF_FFFE);
        send_word(OP_INIT, '0, '0, '0);
        settle_ring();
        // sizes below two fall back to the full ring
        write_reg(CFG_RING_SIZE, 64'd0);
        write_reg(CFG_RING_BASE, 64'hA5A5_A5A5_5A5A_5A5A);
        send_word(OP_INIT, rand64(), $urandom, $urandom);
        settle_ring();
        write_reg(CFG_RING_SIZE, 64'd1);
        send_word(OP_ENQUEUE, rand64(), $urandom, $urandom);
        settle_ring();
        // oversized values saturate at 256
        write_reg(CFG_RING_SIZE, 64'd511);
        send_word(OP_ENQUEUE, rand64(), $urandom, $urandom);
        send_word(OP_INIT, rand64(), $urandom, $urandom);
        settle_ring();
        write_reg(CFG_RING_SIZE, 64'd257);
        send_word(OP_ENQUEUE, rand64(), $urandom, $urandom);
        settle_ring();
        // shrink the ring under an index already past the new link slot
        write_reg(CFG_RING_SIZE, 64'd256);
        repeat (6) send_word(OP_ENQUEUE, rand64(), $urandom, $urandom);
        settle_ring();
        write_reg(CFG_RING_SIZE, 64'd4);
        repeat (4) send_word(OP_ENQUEUE, rand64(), $urandom, $urandom);
        settle_ring();
        write_reg(CFG_RING_SIZE, 64'd3);
        write_reg(CFG_RING_BASE, 64'h5A5A_5A5A_A5A5_A5A5);
        repeat (2) send_word(OP_ENQUEUE, rand64(), $urandom, $urandom);
        send_word(OP_INIT, '0, '0, '0);
        settle_ring();
    endtask

    // full 256-slot ring, enough words for one complete wrap
    task automatic test_full_ring();
        write_reg(CFG_RING_SIZE, 64'd0);
        write_reg(CFG_RING_BASE, rand64());
        send_word(OP_INIT, rand64(), $urandom, $urandom);
        repeat (258) send_random_word(1000);
        settle_ring();
    endtask

    // output held off for a long stretch while words keep coming
    task automatic test_stall_fill();
        write_reg(CFG_RING_SIZE, 64'd5);
        write_reg(CFG_RING_BASE, rand64());
        hold_req++;
        repeat (30) send_random_word(30);
        settle_ring();
    endtask

    task automatic test_random_phases();
        int n;
        while (words_sent < 490)
        begin
            write_reg(CFG_RING_SIZE, {55'd0, pick_slot_count()});
            if ($urandom_range(0, 2) != 0)
                write_reg(CFG_RING_BASE, rand64());
            n = $urandom_range(5, 30);
            repeat (n) send_random_word(19);
            settle_ring();
        end
    endtask

    // back-to-back words with no idling on either side
    task automatic test_steady_stream();
        tx_idling = 1'b0;
        rx_idling = 1'b0;
        write_reg(CFG_RING_SIZE, {55'd0, 9'($urandom_range(2, 12))});
        repeat (60) send_random_word(25);
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_full_ring();
        test_stall_fill();
        test_random_phases();
        test_steady_stream();
        settle_ring();
        repeat (8) @(posedge clk);
        if (slot_writes_due.size() != 0)
            report_mismatch($sformatf("%0d writes never arrived", slot_writes_due.size()));
        $display("Sent %0d words (%0d init), checked %0d slot writes, %0d link writes",
                 words_sent, init_words, writes_checked, link_writes);
        $display("Covered %0d register writes: ring sizes 0 to 511, wraps, long output hold",
                 reg_writes);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
